// File: src/v3alu_pkg.sv
// Shared types, constants and codes for the three-component vector ALU.
package v3alu_pkg;

  // Field and datapath widths
  localparam int FIELD_W = 32;
  localparam int PROD_W = 64;
  localparam int PRE_W = 66;
  localparam int SS_W = 64;
  localparam int ROOT_W = 32;
  localparam int SQ_REM_W = 35;
  localparam int DVD_W = 64;
  localparam int DVS_W = 32;
  localparam int Q_W = 32;
  localparam int LANES = 3;

  // Iterations done per pipeline stage in the square root and divider
  localparam int SQ_PER = 4;
  localparam int SQ_STAGES = ROOT_W / SQ_PER;
  localparam int DV_PER = 4;
  localparam int DV_STAGES = Q_W / DV_PER;

  // Parameter defaults
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_WORD_WIDTH = 32;

  typedef logic signed [FIELD_W-1:0] word_t;

  // Operation codes
  typedef enum logic [4:0] {
    MODE_ADD   = 5'd0,
    MODE_SUB   = 5'd1,
    MODE_MUL   = 5'd2,
    MODE_DIV   = 5'd3,
    MODE_SCALE = 5'd4,
    MODE_SDIV  = 5'd5,
    MODE_NEG   = 5'd6,
    MODE_DOT   = 5'd7,
    MODE_CROSS = 5'd8,
    MODE_LEN   = 5'd9,
    MODE_NORM  = 5'd10,
    MODE_ABS   = 5'd11,
    MODE_MAX   = 5'd12,
    MODE_SMAX  = 5'd13,
    MODE_MOD   = 5'd14,
    MODE_UMOD  = 5'd15,
    MODE_SADD  = 5'd16,
    MODE_SSUB  = 5'd17
  } mode_t;

  // How the final stage forms a lane's result
  typedef enum logic [2:0] {
    K_DIRECT,
    K_LEN,
    K_DIV,
    K_NORM,
    K_MODF,
    K_MODT,
    K_ERR
  } kind_t;

  typedef struct packed {
    logic [4:0] mode;
    word_t      ax;
    word_t      ay;
    word_t      az;
    word_t      bx;
    word_t      by;
    word_t      bz;
  } in_item_t;

  typedef struct packed {
    word_t rx;
    word_t ry;
    word_t rz;
    logic  saturated;
    logic  arith_error;
  } out_item_t;

  // Per-lane operation prepared ahead of the square root
  typedef struct packed {
    kind_t                    kind;
    logic signed [PRE_W-1:0]  pre;
    logic [DVD_W-1:0]         dvd;
    logic [DVS_W-1:0]         dvs;
    logic                     neg;
  } lane_op_t;

  // Square root stage contents
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [SS_W-1:0]     rad;
  } sq_st_t;

  // Divider stage contents
  typedef struct packed {
    kind_t                    kind;
    logic signed [PRE_W-1:0]  pre;
    logic                     neg;
    logic                     dz;
    logic                     ovf;
    logic                     dvd_zero;
    logic [DVS_W-1:0]         dvs;
    logic [DVS_W-1:0]         rem;
    logic [Q_W-1:0]           low;
    logic [Q_W-1:0]           q;
  } div_st_t;

endpackage

// File: src/v3alu_mul_lane.sv
// One multiplier lane: picks operands for its component and forms two products.
module v3alu_mul_lane #(
  parameter int LANE = 0
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [4:0]                              mode,
  input  v3alu_pkg::word_t                        a [v3alu_pkg::LANES],
  input  v3alu_pkg::word_t                        b [v3alu_pkg::LANES],
  output logic signed [v3alu_pkg::PROD_W-1:0]     p0,
  output logic signed [v3alu_pkg::PROD_W-1:0]     p1
);

  localparam int J = (LANE + 1) % v3alu_pkg::LANES;
  localparam int K = (LANE + 2) % v3alu_pkg::LANES;

  v3alu_pkg::word_t x0, y0, x1, y1;
  logic signed [v3alu_pkg::PROD_W-1:0] p0_r, p1_r;

  // operand select; the second product only matters for cross
  always_comb begin
    x1 = a[K];
    y1 = b[J];
    unique case (mode)
      v3alu_pkg::MODE_CROSS: begin
        x0 = a[J];
        y0 = b[K];
      end
      v3alu_pkg::MODE_SCALE: begin
        x0 = a[LANE];
        y0 = b[0];
      end
      v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_NORM: begin
        x0 = a[LANE];
        y0 = a[LANE];
      end
      default: begin
        x0 = a[LANE];
        y0 = b[LANE];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= x0 * y0;
      p1_r <= x1 * y1;
    end
  end

  assign p0 = p0_r;
  assign p1 = p1_r;

endmodule

// File: src/v3alu_sqrt.sv
// Pipelined integer square root, two radicand bits per iteration.
module v3alu_sqrt (
  input  logic                                clk,
  input  logic [v3alu_pkg::SQ_STAGES-1:0]     en,
  input  logic [v3alu_pkg::SS_W-1:0]          ss,
  output logic [v3alu_pkg::ROOT_W-1:0]        root
);

  v3alu_pkg::sq_st_t st_r [v3alu_pkg::SQ_STAGES];

  for (genvar s = 0; s < v3alu_pkg::SQ_STAGES; s++) begin : g_st
    v3alu_pkg::sq_st_t cur;
    v3alu_pkg::sq_st_t st_nxt;
    logic [v3alu_pkg::SQ_REM_W-1:0] r;
    logic [v3alu_pkg::SQ_REM_W-1:0] trial;

    // a few restoring root steps per stage
    always_comb begin
      if (s == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.rad  = ss;
      end else begin
        cur = st_r[(s == 0) ? 0 : s - 1];
      end
      r = '0;
      trial = '0;
      for (int j = 0; j < v3alu_pkg::SQ_PER; j++) begin
        r = {cur.rem[v3alu_pkg::SQ_REM_W-3:0], cur.rad[v3alu_pkg::SS_W-1 -: 2]};
        cur.rad = cur.rad << 2;
        trial = {1'b0, cur.root, 2'b01};
        if (r >= trial) begin
          cur.rem  = r - trial;
          cur.root = {cur.root[v3alu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          cur.rem  = r;
          cur.root = {cur.root[v3alu_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      st_nxt = cur;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s] <= st_nxt;
      end
    end
  end

  assign root = st_r[v3alu_pkg::SQ_STAGES-1].root;

endmodule

// File: src/v3alu_div_lane.sv
// One divider lane: divisor setup then a pipelined restoring divide.
module v3alu_div_lane (
  input  logic                                  clk,
  input  logic [v3alu_pkg::DV_STAGES:0]         en,
  input  v3alu_pkg::lane_op_t                   op,
  input  logic [v3alu_pkg::ROOT_W-1:0]          len,
  output v3alu_pkg::div_st_t                    res
);

  v3alu_pkg::div_st_t st_r [v3alu_pkg::DV_STAGES+1];
  v3alu_pkg::div_st_t setup_nxt;
  logic [v3alu_pkg::DVS_W-1:0] divisor;
  logic uses_div;

  // pick divisor, flag zero divisor and quotients of 2^32 or more
  always_comb begin
    divisor = (op.kind == v3alu_pkg::K_NORM) ? len : op.dvs;
    uses_div = (op.kind == v3alu_pkg::K_DIV) || (op.kind == v3alu_pkg::K_NORM) ||
               (op.kind == v3alu_pkg::K_MODF) || (op.kind == v3alu_pkg::K_MODT);
    setup_nxt.kind     = op.kind;
    setup_nxt.pre      = (op.kind == v3alu_pkg::K_LEN) ?
                         v3alu_pkg::PRE_W'({1'b0, len}) : op.pre;
    setup_nxt.neg      = op.neg;
    setup_nxt.dz       = uses_div && (divisor == '0);
    setup_nxt.ovf      = op.dvd[v3alu_pkg::DVD_W-1 -: v3alu_pkg::DVS_W] >= divisor;
    setup_nxt.dvd_zero = (op.dvd == '0);
    setup_nxt.dvs      = divisor;
    setup_nxt.rem      = op.dvd[v3alu_pkg::DVD_W-1 -: v3alu_pkg::DVS_W];
    setup_nxt.low      = op.dvd[v3alu_pkg::Q_W-1:0];
    setup_nxt.q        = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st_r[0] <= setup_nxt;
    end
  end

  for (genvar s = 1; s <= v3alu_pkg::DV_STAGES; s++) begin : g_st
    v3alu_pkg::div_st_t cur;
    logic [v3alu_pkg::DVS_W:0] t;

    // a few quotient bits per stage
    always_comb begin
      cur = st_r[s-1];
      t = '0;
      for (int j = 0; j < v3alu_pkg::DV_PER; j++) begin
        t = {cur.rem, cur.low[v3alu_pkg::Q_W-1]};
        cur.low = cur.low << 1;
        if (t >= {1'b0, cur.dvs}) begin
          cur.rem = v3alu_pkg::DVS_W'(t - {1'b0, cur.dvs});
          cur.q   = {cur.q[v3alu_pkg::Q_W-2:0], 1'b1};
        end else begin
          cur.rem = t[v3alu_pkg::DVS_W-1:0];
          cur.q   = {cur.q[v3alu_pkg::Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s] <= cur;
      end
    end
  end

  assign res = st_r[v3alu_pkg::DV_STAGES];

endmodule

// File: src/v3alu_merge.sv
// Final stage: forms each lane's value, saturates, merges flags, output register.
module v3alu_merge #(
  parameter int WORD_WIDTH = v3alu_pkg::DEF_WORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   en,
  input  v3alu_pkg::div_st_t     lane [v3alu_pkg::LANES],
  output v3alu_pkg::out_item_t   out_item
);

  localparam int SAT_W = (WORD_WIDTH > v3alu_pkg::FIELD_W) ? v3alu_pkg::FIELD_W : WORD_WIDTH;
  localparam logic signed [v3alu_pkg::PRE_W-1:0] SAT_HI =
    v3alu_pkg::PRE_W'((longint'(1) <<< (SAT_W - 1)) - longint'(1));
  localparam logic signed [v3alu_pkg::PRE_W-1:0] SAT_LO = -SAT_HI - 1;

  logic signed [v3alu_pkg::PRE_W-1:0] val [v3alu_pkg::LANES];
  v3alu_pkg::word_t res [v3alu_pkg::LANES];
  logic [v3alu_pkg::LANES-1:0] sat_f, err_f;
  v3alu_pkg::out_item_t out_nxt, out_r;

  // per-lane value and flags
  always_comb begin
    for (int i = 0; i < v3alu_pkg::LANES; i++) begin
      err_f[i] = 1'b0;
      unique case (lane[i].kind)
        v3alu_pkg::K_DIRECT, v3alu_pkg::K_LEN: val[i] = lane[i].pre;
        v3alu_pkg::K_DIV, v3alu_pkg::K_NORM: begin
          if (lane[i].dz) begin
            err_f[i] = 1'b1;
            if (lane[i].kind == v3alu_pkg::K_NORM || lane[i].dvd_zero) begin
              val[i] = '0;
            end else begin
              val[i] = lane[i].neg ? SAT_LO - 1 : SAT_HI + 1;
            end
          end else if (lane[i].ovf) begin
            val[i] = lane[i].neg ? SAT_LO - 1 : SAT_HI + 1;
          end else begin
            val[i] = lane[i].neg ? -v3alu_pkg::PRE_W'(lane[i].q) :
                                   v3alu_pkg::PRE_W'(lane[i].q);
          end
        end
        v3alu_pkg::K_MODT: begin
          val[i] = lane[i].neg ? -v3alu_pkg::PRE_W'(lane[i].rem) :
                                 v3alu_pkg::PRE_W'(lane[i].rem);
        end
        v3alu_pkg::K_MODF: begin
          if (lane[i].neg && lane[i].rem != '0) begin
            val[i] = v3alu_pkg::PRE_W'(lane[i].dvs) - v3alu_pkg::PRE_W'(lane[i].rem);
          end else begin
            val[i] = v3alu_pkg::PRE_W'(lane[i].rem);
          end
        end
        v3alu_pkg::K_ERR: begin
          val[i] = '0;
          err_f[i] = 1'b1;
        end
        default: val[i] = '0;
      endcase

      // clamp to the signed word
      if (val[i] > SAT_HI) begin
        res[i] = SAT_HI[v3alu_pkg::FIELD_W-1:0];
        sat_f[i] = 1'b1;
      end else if (val[i] < SAT_LO) begin
        res[i] = SAT_LO[v3alu_pkg::FIELD_W-1:0];
        sat_f[i] = 1'b1;
      end else begin
        res[i] = val[i][v3alu_pkg::FIELD_W-1:0];
        sat_f[i] = 1'b0;
      end
    end
    out_nxt.rx = res[0];
    out_nxt.ry = res[1];
    out_nxt.rz = res[2];
    out_nxt.saturated = |sat_f;
    out_nxt.arith_error = |err_f;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// File: src/vec3_fixed_point_alu.sv
// Top level of the three-component Q16.16 vector ALU pipeline.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one item: an operation
//   code and two vectors (bx doubles as the scalar operand). Result channel
//   out_valid/out_ready/out_data returns one item per input item, in order:
//   rx, ry, rz and the saturated and arith_error flags.
//   Throughput: one item per cycle with any mix of operations, while out_ready stays high.
//   Depth: the pipeline length is set by the 32-bit square root (8 stages,
//   4 root bits each) feeding the 32-bit restoring divider (setup plus 8
//   stages, 4 quotient bits each), which every item passes through so
//   that order is kept.
//   Stall: each stage holds only while the stage after it holds, so the
//   pipeline fills its bubbles and keeps accepting while a result waits
//   in the output register; in_ready drops once every stage is full.
//   Reset: rst_n (synchronous, active low) clears all valid bits; no item
//   is in flight afterward. The data registers are not reset.
module vec3_fixed_point_alu #(
  parameter int FRAC_BITS  = v3alu_pkg::DEF_FRAC_BITS,
  parameter int WORD_WIDTH = v3alu_pkg::DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  v3alu_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output v3alu_pkg::out_item_t  out_data
);

  localparam int ST_MUL = 2;
  localparam int ST_PRE = 3;
  localparam int ST_SQ0 = 4;
  localparam int ST_DV0 = ST_SQ0 + v3alu_pkg::SQ_STAGES;
  localparam int NST = ST_DV0 + v3alu_pkg::DV_STAGES + 1;
  localparam int L = v3alu_pkg::LANES;

  logic [NST:1] v_r, hold, en;
  logic [NST:0] vc;

  v3alu_pkg::in_item_t s1_r, s2_r;
  v3alu_pkg::word_t a1 [L], b1 [L], a2 [L], b2 [L];
  logic signed [v3alu_pkg::PROD_W-1:0] p0 [L], p1 [L];
  logic signed [v3alu_pkg::PROD_W-1:0] fp0 [L], fp1 [L];
  v3alu_pkg::lane_op_t op3_nxt [L], op3_r [L];
  v3alu_pkg::lane_op_t opq_r [v3alu_pkg::SQ_STAGES][L];
  logic [v3alu_pkg::SS_W-1:0] ss_nxt, ss3_r;
  logic [v3alu_pkg::ROOT_W-1:0] len;
  v3alu_pkg::div_st_t dres [L];

  // stall chain: a stage holds when it is full and its successor holds
  always_comb begin
    hold[NST] = v_r[NST] && !out_ready;
    for (int k = NST - 1; k >= 1; k--) begin
      hold[k] = v_r[k] && hold[k+1];
    end
  end

  assign en = ~hold;
  assign vc = {v_r, in_valid};
  assign in_ready = en[1];
  assign out_valid = v_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) begin
          v_r[k] <= vc[k-1];
        end
      end
    end
  end

  // input register and the copy that travels with the products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_r <= in_data;
    end
    if (en[ST_MUL]) begin
      s2_r <= s1_r;
    end
  end

  assign a1 = '{s1_r.ax, s1_r.ay, s1_r.az};
  assign b1 = '{s1_r.bx, s1_r.by, s1_r.bz};
  assign a2 = '{s2_r.ax, s2_r.ay, s2_r.az};
  assign b2 = '{s2_r.bx, s2_r.by, s2_r.bz};

  // multiplier lanes
  for (genvar i = 0; i < L; i++) begin : g_mul
    v3alu_mul_lane #(
      .LANE(i)
    ) u_mul (
      .clk (clk),
      .en  (en[ST_MUL]),
      .mode(s1_r.mode),
      .a   (a1),
      .b   (b1),
      .p0  (p0[i]),
      .p1  (p1[i])
    );
  end

  // floored products, lane values and divider operands
  always_comb begin
    for (int i = 0; i < L; i++) begin
      fp0[i] = p0[i] >>> FRAC_BITS;
      fp1[i] = p1[i] >>> FRAC_BITS;
    end
    ss_nxt = v3alu_pkg::SS_W'(p0[0]) + v3alu_pkg::SS_W'(p0[1]) + v3alu_pkg::SS_W'(p0[2]);
    for (int i = 0; i < L; i++) begin
      op3_nxt[i].kind = v3alu_pkg::K_DIRECT;
      op3_nxt[i].pre  = '0;
      op3_nxt[i].dvd  = '0;
      op3_nxt[i].dvs  = '0;
      op3_nxt[i].neg  = a2[i] < 0;
      unique case (s2_r.mode)
        v3alu_pkg::MODE_ADD:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(a2[i]) + v3alu_pkg::PRE_W'(b2[i]);
        v3alu_pkg::MODE_SUB:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(a2[i]) - v3alu_pkg::PRE_W'(b2[i]);
        v3alu_pkg::MODE_SADD:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(a2[i]) + v3alu_pkg::PRE_W'(b2[0]);
        v3alu_pkg::MODE_SSUB:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(a2[i]) - v3alu_pkg::PRE_W'(b2[0]);
        v3alu_pkg::MODE_NEG:
          op3_nxt[i].pre = -v3alu_pkg::PRE_W'(a2[i]);
        v3alu_pkg::MODE_ABS:
          op3_nxt[i].pre = (a2[i] < 0) ? -v3alu_pkg::PRE_W'(a2[i]) :
                                         v3alu_pkg::PRE_W'(a2[i]);
        v3alu_pkg::MODE_MAX:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'((a2[i] > b2[i]) ? a2[i] : b2[i]);
        v3alu_pkg::MODE_SMAX:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'((a2[i] > b2[0]) ? a2[i] : b2[0]);
        v3alu_pkg::MODE_MUL, v3alu_pkg::MODE_SCALE:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(fp0[i]);
        v3alu_pkg::MODE_CROSS:
          op3_nxt[i].pre = v3alu_pkg::PRE_W'(fp0[i]) - v3alu_pkg::PRE_W'(fp1[i]);
        v3alu_pkg::MODE_DOT: begin
          if (i == 0) begin
            op3_nxt[i].pre = v3alu_pkg::PRE_W'(fp0[0]) + v3alu_pkg::PRE_W'(fp0[1]) +
                             v3alu_pkg::PRE_W'(fp0[2]);
          end
        end
        v3alu_pkg::MODE_LEN: begin
          if (i == 0) begin
            op3_nxt[i].kind = v3alu_pkg::K_LEN;
          end
        end
        v3alu_pkg::MODE_NORM: begin
          op3_nxt[i].kind = v3alu_pkg::K_NORM;
          op3_nxt[i].dvd  = v3alu_pkg::DVD_W'($unsigned(
                              (a2[i] < 0) ? -a2[i] : a2[i])) << FRAC_BITS;
        end
        v3alu_pkg::MODE_DIV, v3alu_pkg::MODE_SDIV: begin
          op3_nxt[i].kind = v3alu_pkg::K_DIV;
          op3_nxt[i].dvd  = v3alu_pkg::DVD_W'($unsigned(
                              (a2[i] < 0) ? -a2[i] : a2[i])) << FRAC_BITS;
          if (s2_r.mode == v3alu_pkg::MODE_DIV) begin
            op3_nxt[i].dvs = v3alu_pkg::DVS_W'((b2[i] < 0) ? -b2[i] : b2[i]);
            op3_nxt[i].neg = (a2[i] < 0) ^ (b2[i] < 0);
          end else begin
            op3_nxt[i].dvs = v3alu_pkg::DVS_W'((b2[0] < 0) ? -b2[0] : b2[0]);
            op3_nxt[i].neg = (a2[i] < 0) ^ (b2[0] < 0);
          end
        end
        v3alu_pkg::MODE_MOD, v3alu_pkg::MODE_UMOD: begin
          if (b2[0] <= 0) begin
            op3_nxt[i].kind = v3alu_pkg::K_ERR;
          end else begin
            op3_nxt[i].kind = (s2_r.mode == v3alu_pkg::MODE_MOD) ?
                              v3alu_pkg::K_MODF : v3alu_pkg::K_MODT;
            op3_nxt[i].dvd  = v3alu_pkg::DVD_W'($unsigned(
                                (a2[i] < 0) ? -a2[i] : a2[i]));
            op3_nxt[i].dvs  = v3alu_pkg::DVS_W'(b2[0]);
          end
        end
        default: op3_nxt[i].pre = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PRE]) begin
      op3_r <= op3_nxt;
      ss3_r <= ss_nxt;
    end
  end

  // square root of the sum of squares
  v3alu_sqrt u_sqrt (
    .clk (clk),
    .en  (en[ST_SQ0 +: v3alu_pkg::SQ_STAGES]),
    .ss  (ss3_r),
    .root(len)
  );

  // lane operations ride alongside the root
  for (genvar k = 0; k < v3alu_pkg::SQ_STAGES; k++) begin : g_opq
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[ST_SQ0]) begin
          opq_r[0] <= op3_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[ST_SQ0+k]) begin
          opq_r[k] <= opq_r[k-1];
        end
      end
    end
  end

  // divider lanes
  for (genvar i = 0; i < L; i++) begin : g_div
    v3alu_div_lane u_div (
      .clk(clk),
      .en (en[ST_DV0 +: v3alu_pkg::DV_STAGES+1]),
      .op (opq_r[v3alu_pkg::SQ_STAGES-1][i]),
      .len(len),
      .res(dres[i])
    );
  end

  // merge lanes into the output register
  v3alu_merge #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_merge (
    .clk     (clk),
    .en      (en[NST]),
    .lane    (dres),
    .out_item(out_data)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the three-component Q16.16 vector ALU.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int LATENCY = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  // highest code with no operation behind it
  localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  v3alu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  v3alu_pkg::out_item_t out_data;

  v3alu_pkg::out_item_t result_queue[$];
  int mismatch_count = 0;
  int result_count = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit allow_gaps = 1'b1;
  bit hold_receiver = 1'b0;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  vec3_fixed_point_alu DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // ---------------- prediction ----------------
  function automatic longint clamp_word(input longint v, inout bit sat);
    if (v > WMAX) begin
      sat = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      sat = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // Exact product floored to the fraction width
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic longint fx_div(input longint a, input longint b, inout bit sat,
                                     inout bit err);
    if (b == 0) begin
      err = 1'b1;
      if (a > 0) return clamp_word(WMAX + 1, sat);
      if (a < 0) return clamp_word(WMIN - 1, sat);
      return 0;
    end
    return clamp_word((a <<< FRAC) / b, sat);
  endfunction

  function automatic longint int_sqrt(input logic [63:0] v);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'h1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return longint'(res);
  endfunction

  function automatic v3alu_pkg::out_item_t predict_alu(input v3alu_pkg::in_item_t it);
    longint a[3], b[3], r[3], len, m, t;
    logic [63:0] ss;
    bit sat, err;
    v3alu_pkg::out_item_t o;
    a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
    b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
    r[0] = 0; r[1] = 0; r[2] = 0;
    sat = 0; err = 0;
    case (it.mode)
      v3alu_pkg::MODE_ADD:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], sat);
      v3alu_pkg::MODE_SUB:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], sat);
      v3alu_pkg::MODE_MUL:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(fx_mul(a[i], b[i]), sat);
      v3alu_pkg::MODE_DIV:
        for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], b[i], sat, err);
      v3alu_pkg::MODE_SCALE:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(fx_mul(a[i], b[0]), sat);
      v3alu_pkg::MODE_SDIV:
        for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], b[0], sat, err);
      v3alu_pkg::MODE_NEG:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(-a[i], sat);
      v3alu_pkg::MODE_DOT:
        r[0] = clamp_word(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]), sat);
      v3alu_pkg::MODE_CROSS: begin
        r[0] = clamp_word(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]), sat);
        r[1] = clamp_word(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]), sat);
        r[2] = clamp_word(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]), sat);
      end
      v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_NORM: begin
        ss = 0;
        for (int i = 0; i < 3; i++) ss = ss + 64'(a[i] * a[i]);
        len = int_sqrt(ss);
        if (it.mode == v3alu_pkg::MODE_LEN) r[0] = clamp_word(len, sat);
        else if (len == 0) err = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] <<< FRAC) / len, sat);
      end
      v3alu_pkg::MODE_ABS:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] < 0 ? -a[i] : a[i], sat);
      v3alu_pkg::MODE_MAX:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] > b[i] ? a[i] : b[i], sat);
      v3alu_pkg::MODE_SMAX:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] > b[0] ? a[i] : b[0], sat);
      v3alu_pkg::MODE_MOD, v3alu_pkg::MODE_UMOD: begin
        m = b[0];
        if (m <= 0) err = 1'b1;
        else for (int i = 0; i < 3; i++) begin
          t = a[i] % m;
          if (it.mode == v3alu_pkg::MODE_MOD && t < 0) t = t + m;
          r[i] = clamp_word(t, sat);
        end
      end
      v3alu_pkg::MODE_SADD:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[0], sat);
      v3alu_pkg::MODE_SSUB:
        for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[0], sat);
      default: ;
    endcase
    o.rx = r[0][31:0]; o.ry = r[1][31:0]; o.rz = r[2][31:0];
    o.saturated = sat; o.arith_error = err;
    return o;
  endfunction

  // ---------------- sender ----------------
  task automatic send_item(input v3alu_pkg::in_item_t it);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_queue.push_back(predict_alu(it));
    sent_count++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  function automatic v3alu_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return v3alu_pkg::word_t'(32'h7fffffff);
      1: return v3alu_pkg::word_t'(32'h80000000);
      2: return v3alu_pkg::word_t'(0);
      3: return v3alu_pkg::word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      4: return v3alu_pkg::word_t'($signed($urandom_range(0, 32'h7ffffff)) - 32'sh3ffffff);
      default: return v3alu_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic v3alu_pkg::in_item_t rand_item();
    v3alu_pkg::in_item_t it;
    it.mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                           : 5'($urandom_range(0, 17));
    it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
    it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
    return it;
  endfunction

  function automatic v3alu_pkg::in_item_t make_item(
      input logic [4:0] md, input v3alu_pkg::word_t ax, input v3alu_pkg::word_t ay,
      input v3alu_pkg::word_t az, input v3alu_pkg::word_t bx, input v3alu_pkg::word_t by,
      input v3alu_pkg::word_t bz);
    v3alu_pkg::in_item_t it;
    it.mode = md; it.ax = ax; it.ay = ay; it.az = az; it.bx = bx; it.by = by; it.bz = bz;
    return it;
  endfunction

  task automatic wait_drained();
    go_idle();
    while (result_queue.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    v3alu_pkg::word_t mx, mn, one;
    mx = 32'sh7fffffff; mn = 32'sh80000000; one = 32'sh00010000;
    // every operation on plain values
    for (int m = 0; m <= 17; m++)
      send_item(make_item(5'(m), one, -2 * one, 3 * one, 2 * one, one, -one));
    // extremes and special cases
    send_item(make_item(v3alu_pkg::MODE_ADD, mx, mn, mx, mx, mn, 1));
    send_item(make_item(v3alu_pkg::MODE_DIV, one, -one, 0, 0, 0, 0));
    send_item(make_item(v3alu_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0));
    send_item(make_item(v3alu_pkg::MODE_MOD, -5 * one, one, 0, 0, 0, 0));
    send_item(make_item(v3alu_pkg::MODE_UMOD, -5 * one, one, 7, -one, 0, 0));
    send_item(make_item(v3alu_pkg::MODE_NEG, mn, mx, 0, 0, 0, 0));
    send_item(make_item(v3alu_pkg::MODE_ABS, mn, -1, 1, 0, 0, 0));
    send_item(make_item(MODE_UNUSED_TOP, mx, mn, one, one, one, one));
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  // Receiver holds off while items keep coming, so the pipeline fills
  task automatic test_backpressure();
    hold_cycles = 80;
    hold_receiver = 1'b1;
    test_random(60);
    wait_drained();
  endtask

  task automatic test_streaming(input int count);
    allow_gaps = 1'b0;
    test_random(count);
    wait_drained();
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (hold_receiver) begin
      out_ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else hold_receiver <= 1'b0;
    end else if (allow_gaps && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    v3alu_pkg::out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (result_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_item = result_queue.pop_front();
        if (exp_item.rx !== out_data.rx || exp_item.ry !== out_data.ry ||
            exp_item.rz !== out_data.rz || exp_item.saturated !== out_data.saturated ||
            exp_item.arith_error !== out_data.arith_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h %h %h s%0b e%0b, got %h %h %h s%0b e%0b",
                     exp_item.rx, exp_item.ry, exp_item.rz, exp_item.saturated,
                     exp_item.arith_error, out_data.rx, out_data.ry, out_data.rz,
                     out_data.saturated, out_data.arith_error);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("[vec3_fixed_point_alu] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(900);
    wait_drained();
    test_backpressure();
    test_random(500);
    test_streaming(400);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d items, %0d results: all 18 operations, unused codes, extremes,",
             sent_count, result_count);
    $display("divide by zero, zero normalize, bad modulus, stalls and full-rate streaming.");
    if (mismatch_count == 0 && result_queue.size() == 0) begin
      $display("[vec3_fixed_point_alu] OK");
    end else begin
      $display("[vec3_fixed_point_alu] ERROR");
    end
    $finish;
  end
endmodule
